### rtl/pepper_noise_hole_fill_assert.svh
// Assertion macros for the pepper noise hole fill block.
`ifndef PEPPER_NOISE_HOLE_FILL_ASSERT_SVH
`define PEPPER_NOISE_HOLE_FILL_ASSERT_SVH

`ifndef SYNTH
// Concurrent property check, disabled while reset is asserted.
`define PNHF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold at a clock edge.
`define PNHF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PNHF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PNHF_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/pnhf_pkg.sv
// Types, codes and window tables for the pepper noise hole fill block.
`default_nettype none
package pnhf_pkg;

	localparam int DIM_W = 9;
	localparam int N_W = 2 * DIM_W;
	localparam logic [DIM_W-1:0] MIN_DIM = 9'd5;
	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
	localparam logic [7:0] FILL_VALUE = 8'd255;
	localparam logic [4:0] RING_N = 5'd16;
	localparam logic [3:0] FILL_LAST = 4'd8;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_RUN    = 2'd1,
		REQ_READ   = 2'd2,
		REQ_IGNORE = 2'd3
	} req_code_t;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic KIND_PASS_DONE = 1'b0;
	localparam logic KIND_PIXEL     = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] pixel_in;
	} req_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] pixel_out;
		logic       last_pixel;
	} res_item_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_ROW,
		P_CRD,
		P_CEV,
		P_RING,
		P_FILL,
		P_DONE
	} pass_state_t;

	// Ring of the 5x5 window: row and column code 0..4, centre at 2.
	function automatic logic [2:0] ring_dy(input logic [3:0] k);
		logic [2:0] r;
		if (k < 4'd5) r = 3'd0;
		else if (k < 4'd10) r = 3'd4;
		else if (k < 4'd13) r = 3'(k - 4'd9);
		else r = 3'(k - 4'd12);
		return r;
	endfunction

	function automatic logic [2:0] ring_dx(input logic [3:0] k);
		logic [2:0] r;
		if (k < 4'd5) r = 3'(k);
		else if (k < 4'd10) r = 3'(k - 4'd5);
		else if (k < 4'd13) r = 3'd0;
		else r = 3'd4;
		return r;
	endfunction

	// Inner 3x3 block, same coding.
	function automatic logic [2:0] fill_dy(input logic [3:0] f);
		logic [2:0] r;
		if (f < 4'd3) r = 3'd1;
		else if (f < 4'd6) r = 3'd2;
		else r = 3'd3;
		return r;
	endfunction

	function automatic logic [2:0] fill_dx(input logic [3:0] f);
		logic [2:0] r;
		if (f < 4'd3) r = 3'(f + 4'd1);
		else if (f < 4'd6) r = 3'(f - 4'd2);
		else r = 3'(f - 4'd5);
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/pnhf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pnhf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/pepper_noise_hole_fill.sv
// Load pixel: one beat per cycle while no pass runs and frame size has settled. Read pixel: the
// result goes through the RAM read register into the output register, and no new read or run is
// taken while a read is pending. Run: a plain centre is read, then checked; a hole adds a ring
// check and a 3x3 fill and skips three columns, paced by the single frame store read port.
// Reset is asynchronous: clears positions, dimensions (256) and control, not the frame store.
// After reset or a config write the request side stalls, through settle_q, while frame size settles.
`default_nettype none
`include "pepper_noise_hole_fill_assert.svh"
module pepper_noise_hole_fill
	import pnhf_pkg::*;
#(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  req_item_t        req_data,
	output logic             res_valid,
	input  wire              res_stall,
	output res_item_t        res_data,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [0:0]        cfg_index,
	input  wire [DIM_W-1:0]  cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	// ---------------------------------------------------------------- config
	logic [DIM_W-1:0] cfg_w_q, cfg_h_q;
	logic             settle_q;
	logic [DIM_W-1:0] eff_w, eff_h;
	logic [N_W-1:0]   n_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= DIM_RESET;
			cfg_h_q  <= DIM_RESET;
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_valid;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  cfg_w_q <= cfg_data;
					REG_FRAME_HEIGHT: cfg_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Clamp to [5, MAX]; values are only ever compared widened, so large MAX is fine.
	always_comb begin
		if (cfg_w_q < MIN_DIM) eff_w = MIN_DIM;
		else if (32'(cfg_w_q) > MAX_WIDTH) eff_w = DIM_W'(MAX_WIDTH);
		else eff_w = cfg_w_q;
		if (cfg_h_q < MIN_DIM) eff_h = MIN_DIM;
		else if (32'(cfg_h_q) > MAX_HEIGHT) eff_h = DIM_W'(MAX_HEIGHT);
		else eff_h = cfg_h_q;
	end

	// Pixel count, registered from the clamped dimensions, so it lags the dimension registers (covered by settle_q).
	always_ff @(posedge clk) begin
		n_q <= N_W'(eff_w) * N_W'(eff_h);
	end

	// ---------------------------------------------------------------- requests
	logic          req_acc, load_acc, read_acc, run_acc;
	logic          needs_slot, slot_ok;
	logic          rd_pend_s1, rd_last_s1;
	logic          out_valid_q;
	res_item_t     out_q;
	logic [AW-1:0] load_pos_q, read_pos_q;
	logic [AW-1:0] load_addr, read_addr;
	logic          load_last, read_last;
	pass_state_t   state_q, state_d;

	assign needs_slot = (req_data.req_type == REQ_RUN) || (req_data.req_type == REQ_READ);
	// A result may only be started when the output register is free by the time it lands.
	assign slot_ok   = !rd_pend_s1 && (!out_valid_q || !res_stall);
	assign req_stall = settle_q || (state_q != P_IDLE) || (needs_slot && !slot_ok);
	assign req_acc   = req_valid && !req_stall;
	assign load_acc  = req_acc && (req_data.req_type == REQ_LOAD);
	assign run_acc   = req_acc && (req_data.req_type == REQ_RUN);
	assign read_acc  = req_acc && (req_data.req_type == REQ_READ);

	// Positions past the end (after a size change) restart at zero.
	assign load_addr = (32'(load_pos_q) >= 32'(n_q)) ? '0 : load_pos_q;
	assign read_addr = (32'(read_pos_q) >= 32'(n_q)) ? '0 : read_pos_q;
	assign load_last = (32'(load_addr) + 32'd1) == 32'(n_q);
	assign read_last = (32'(read_addr) + 32'd1) == 32'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			read_pos_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= read_acc;
			if (load_acc) begin
				load_pos_q <= load_last ? '0 : load_addr + AW'(1);
			end
			if (read_acc) begin
				read_pos_q <= read_last ? '0 : read_addr + AW'(1);
			end else if (run_acc) begin
				read_pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= read_last;
	end

	// ---------------------------------------------------------------- cleanup pass
	logic [DIM_W-1:0] w_q, h_q, x_q, y_q;
	logic [DIM_W-1:0] w_d, h_d, x_d, y_d;
	logic [AW-1:0]    cen_q, row_base_q, cen_d, row_base_d;
	logic [4:0]       k_q, k_d;
	logic [3:0]       f_q, f_d;
	logic [2:0]       win_dy, win_dx;
	logic [AW-1:0]    w_a, row_addr, win_addr;
	logic             pass_re, pass_we, pass_done;
	logic [AW-1:0]    pass_raddr;
	logic [7:0]       ram_rdata;

	// Window address: centre plus row offset (-2w..2w) plus column offset (-2..2).
	assign win_dy = (state_q == P_FILL) ? fill_dy(f_q) : ring_dy(k_q[3:0]);
	assign win_dx = (state_q == P_FILL) ? fill_dx(f_q) : ring_dx(k_q[3:0]);
	assign w_a    = AW'(w_q);

	always_comb begin
		case (win_dy)
			3'd0:    row_addr = cen_q - (w_a << 1);
			3'd1:    row_addr = cen_q - w_a;
			3'd3:    row_addr = cen_q + w_a;
			3'd4:    row_addr = cen_q + (w_a << 1);
			default: row_addr = cen_q;
		endcase
		win_addr = row_addr + AW'(win_dx) - AW'(2);
	end

	always_comb begin
		state_d    = state_q;
		w_d        = w_q;
		h_d        = h_q;
		x_d        = x_q;
		y_d        = y_q;
		cen_d      = cen_q;
		row_base_d = row_base_q;
		k_d        = k_q;
		f_d        = f_q;
		pass_re    = 1'b0;
		pass_raddr = cen_q;
		pass_we    = 1'b0;
		pass_done  = 1'b0;
		unique case (state_q)
			P_IDLE: begin
				if (run_acc) begin
					w_d        = eff_w;
					h_d        = eff_h;
					y_d        = DIM_W'(2);
					row_base_d = AW'(eff_w) << 1;
					state_d    = P_ROW;
				end
			end
			P_ROW: begin
				if (({1'b0, y_q} + 10'd2) < {1'b0, h_q}) begin
					x_d     = DIM_W'(2);
					cen_d   = row_base_q + AW'(2);
					state_d = P_CRD;
				end else begin
					state_d = P_DONE;
				end
			end
			P_CRD: begin
				if (({1'b0, x_q} + 10'd2) < {1'b0, w_q}) begin
					pass_re = 1'b1;
					state_d = P_CEV;
				end else begin
					y_d        = y_q + DIM_W'(1);
					row_base_d = row_base_q + w_a;
					state_d    = P_ROW;
				end
			end
			P_CEV: begin
				if (ram_rdata == 8'd0) begin
					k_d     = '0;
					state_d = P_RING;
				end else begin
					x_d     = x_q + DIM_W'(1);
					cen_d   = cen_q + AW'(1);
					state_d = P_CRD;
				end
			end
			P_RING: begin
				// Issue ring read k while checking the data of ring read k-1.
				if (k_q != RING_N) begin
					pass_re    = 1'b1;
					pass_raddr = win_addr;
				end
				if (k_q != 5'd0 && ram_rdata == 8'd0) begin
					x_d     = x_q + DIM_W'(3);
					cen_d   = cen_q + AW'(3);
					state_d = P_CRD;
				end else if (k_q == RING_N) begin
					f_d     = '0;
					state_d = P_FILL;
				end else begin
					k_d = k_q + 5'd1;
				end
			end
			P_FILL: begin
				pass_we = 1'b1;
				if (f_q == FILL_LAST) begin
					x_d     = x_q + DIM_W'(3);
					cen_d   = cen_q + AW'(3);
					state_d = P_CRD;
				end else begin
					f_d = f_q + 4'd1;
				end
			end
			P_DONE: begin
				pass_done = 1'b1;
				state_d   = P_IDLE;
			end
			default: state_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		w_q        <= w_d;
		h_q        <= h_d;
		x_q        <= x_d;
		y_q        <= y_d;
		cen_q      <= cen_d;
		row_base_q <= row_base_d;
		k_q        <= k_d;
		f_q        <= f_d;
	end

	// ---------------------------------------------------------------- frame store
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata;

	// The pass owns both ports while it runs; requests are stalled meanwhile.
	assign ram_we    = pass_we || load_acc;
	assign ram_waddr = pass_we ? win_addr : load_addr;
	assign ram_wdata = pass_we ? FILL_VALUE : req_data.pixel_in;
	assign ram_re    = pass_re || read_acc;
	assign ram_raddr = (state_q != P_IDLE) ? pass_raddr : read_addr;

	pnhf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pass_done || rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pass_done) begin
			out_q <= '{result_kind: KIND_PASS_DONE, pixel_out: 8'd0, last_pixel: 1'b0};
		end else if (rd_pend_s1) begin
			out_q <= '{result_kind: KIND_PIXEL, pixel_out: ram_rdata, last_pixel: rd_last_s1};
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// ---------------------------------------------------------------- checks
	`PNHF_NEVER(a_read_lands_free, clk, arst_n, rd_pend_s1 && out_valid_q, "read beat overwrites result")
	`PNHF_NEVER(a_done_lands_free, clk, arst_n, pass_done && out_valid_q, "pass done overwrites result")
	`PNHF_ASSERT(a_run_starts, clk, arst_n, run_acc |=> (state_q == P_ROW), "run beat did not start pass")
	`PNHF_ASSERT(a_read_pends, clk, arst_n, read_acc |=> rd_pend_s1, "read beat lost")
	`PNHF_NEVER(a_no_accept_busy, clk, arst_n, req_acc && (state_q != P_IDLE), "beat taken during pass")

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for pepper_noise_hole_fill: directed frames, then random frames checked against a model.
module tb;
	import pnhf_pkg::*;

	localparam int MAXW = 256;
	localparam int MAXH = 256;
	localparam int STORE_N = MAXW * MAXH;
	localparam int IDLE_LIMIT = 50000;  // no beat on any channel for this long ends the run
	localparam int SETTLE = 8;          // quiet cycles before a register write
	localparam int SMALL_A = 80;        // small-frame beats before the extreme frames
	localparam int SMALL_B = 200;       // small-frame beats before stopping
	localparam int CALM_AT = 150;       // no idling from here on
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int REPORT_MAX = 100;
	localparam int NO_GAP = -1;

	typedef enum logic [1:0] {
		D_CFG,
		D_FRAME,
		D_REQ
	} dop_t;

	// One row of the directed table. D_FRAME loads a whole frame of req.pixel_in with a
	// hole at the 5x5 centre and, unless cnt is NO_GAP, a second zero at address cnt.
	typedef struct {
		dop_t             op;
		cfg_reg_t         sel;
		logic [DIM_W-1:0] val;
		req_item_t        req;
		int               cnt;
		bit               typed;
		res_item_t        want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_item_t        req_data;
	logic             res_valid;
	logic             res_stall;
	res_item_t        res_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [0:0]       cfg_index;
	logic [DIM_W-1:0] cfg_data;

	// Model of the block: its own frame store, positions and registers.
	logic [7:0]       mask_mem [STORE_N];
	bit               mask_set [STORE_N];  // entry has been loaded at least once
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	int unsigned      load_at;
	int unsigned      read_at;
	res_item_t        due_q [$];           // results still to come, oldest first

	dir_row_t dir_tab [$];
	int       err_count;
	int       small_count;
	int       quiet;
	int       gap_rate;                    // 0: sender never idles, else 1 in gap_rate beats
	bit       in_random;
	bit       count_small;
	bit       calm;
	bit       hold_req;
	bit       hold_done;

	pepper_noise_hole_fill DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---- model ---------------------------------------------------------------

	// Register value as the block uses it: below 5 reads as 5, above the maximum as the maximum.
	function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v < 5) return 5;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic int unsigned frame_n();
		return dim_eff(width_reg, MAXW) * dim_eff(height_reg, MAXH);
	endfunction

	// All 16 border pixels of the 5x5 window round (x, y) nonzero.
	function automatic bit ring_solid(input int unsigned w, input int unsigned x,
			input int unsigned y);
		for (int k = 0; k < 5; k++) begin
			if (mask_mem[(y - 2) * w + x - 2 + k] == 8'd0) return 1'b0;
			if (mask_mem[(y + 2) * w + x - 2 + k] == 8'd0) return 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			if (mask_mem[(y - 1 + k) * w + x - 2] == 8'd0) return 1'b0;
			if (mask_mem[(y - 1 + k) * w + x + 2] == 8'd0) return 1'b0;
		end
		return 1'b1;
	endfunction

	// In-place cleanup: later centres see earlier fills; a hole centre moves the scan on by 3.
	function automatic void fill_holes();
		int unsigned w;
		int unsigned h;
		int unsigned x;
		w = dim_eff(width_reg, MAXW);
		h = dim_eff(height_reg, MAXH);
		for (int unsigned y = 2; y + 2 < h; y++) begin
			x = 2;
			while (x + 2 < w) begin
				if (mask_mem[y * w + x] == 8'd0) begin
					if (ring_solid(w, x, y)) begin
						for (int unsigned dy = 0; dy < 3; dy++)
							for (int unsigned dx = 0; dx < 3; dx++)
								mask_mem[(y - 1 + dy) * w + x - 1 + dx] = FILL_VALUE;
					end
					x += 3;
				end else begin
					x += 1;
				end
			end
		end
	endfunction

	// Apply one accepted request beat; returns 1 and the result when it causes one.
	function automatic bit mask_step(input req_item_t it, output res_item_t r);
		int unsigned n;
		n = frame_n();
		r = '0;
		case (it.req_type)
			REQ_LOAD: begin
				if (load_at >= n) load_at = 0;
				mask_mem[load_at] = it.pixel_in;
				mask_set[load_at] = 1'b1;
				load_at = (load_at + 1 == n) ? 0 : load_at + 1;
				return 1'b0;
			end
			REQ_RUN: begin
				fill_holes();
				read_at = 0;
				r.result_kind = KIND_PASS_DONE;
				return 1'b1;
			end
			REQ_READ: begin
				if (read_at >= n) read_at = 0;
				r.result_kind = KIND_PIXEL;
				r.pixel_out = mask_mem[read_at];
				r.last_pixel = (read_at + 1 == n);
				read_at = (read_at + 1 == n) ? 0 : read_at + 1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// A pass reads the whole frame, so every entry of it must have been loaded.
	function automatic bit frame_loaded();
		int unsigned n;
		n = frame_n();
		for (int unsigned i = 0; i < n; i++)
			if (!mask_set[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit read_ok();
		int unsigned n;
		n = frame_n();
		return mask_set[(read_at >= n) ? 0 : read_at];
	endfunction

	function automatic int load_addr();
		int unsigned n;
		n = frame_n();
		return (load_at >= n) ? 0 : int'(load_at);
	endfunction

	// Sparse holes, plenty of full-scale pixels, so that rings close often enough.
	function automatic logic [7:0] rand_px();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1, 2: return 8'hFF;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// ---- drivers -------------------------------------------------------------

	// Offer one request beat, optionally after a gap, and hold it until taken.
	task automatic send(input req_item_t it, input bit typed, input res_item_t want);
		res_item_t r;
		bit        got;
		if (!calm && gap_rate > 0 && $urandom_range(1, gap_rate) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		got = mask_step(it, r);
		if (got) due_q.push_back(typed ? want : r);
	endtask

	// Random-part request, with the odd unused code mixed in as noise.
	task automatic send_req(input req_code_t c, input logic [7:0] px);
		if (in_random && $urandom_range(0, 29) == 0)
			send(req_item_t'{REQ_IGNORE, 8'($urandom)}, 1'b0, '0);
		send(req_item_t'{c, px}, 1'b0, '0);
		if (count_small) small_count++;
	endtask

	// Reads and passes only where every entry they touch is loaded; otherwise load instead.
	task automatic read_px();
		if (read_ok()) send_req(REQ_READ, 8'($urandom));
		else send_req(REQ_LOAD, rand_px());
	endtask

	task automatic run_pass();
		if (frame_loaded()) send_req(REQ_RUN, 8'($urandom));
		else send_req(REQ_LOAD, rand_px());
	endtask

	// Register writes only once the block has drained: no results due, then a settle gap
	// since a load leaves nothing in the result queue to wait for.
	task automatic write_reg(input cfg_reg_t sel, input logic [DIM_W-1:0] v);
		req_valid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (sel == REG_FRAME_WIDTH) width_reg = v;
		else height_reg = v;
	endtask

	// One frame's worth of traffic: optional resize, load, pass, read back, with some
	// partial loads, early reads and repeated passes. shape 1 is 256 wide, shape 2 is
	// 256 tall; both reuse entries loaded earlier where they can.
	task automatic frame_episode(input int shape);
		logic [DIM_W-1:0] wv;
		logic [DIM_W-1:0] hv;
		int               n;
		int               loads;
		int               reads;
		count_small = (shape == 0);
		calm = (shape == 0 && small_count >= CALM_AT);
		case ($urandom_range(0, 2))
			0: gap_rate = 0;
			1: gap_rate = 4;
			default: gap_rate = 12;
		endcase
		case (shape)
			1: begin
				wv = 9'd511;
				hv = 9'($urandom_range(0, 5));
			end
			2: begin
				wv = 9'($urandom_range(0, 5));
				hv = 9'($urandom_range(256, 511));
			end
			default: begin
				wv = 9'($urandom_range(0, 12));
				hv = 9'($urandom_range(0, 12));
			end
		endcase
		if (shape != 0 || $urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, wv);
				write_reg(REG_FRAME_HEIGHT, hv);
			end else begin
				write_reg(REG_FRAME_HEIGHT, hv);
				write_reg(REG_FRAME_WIDTH, wv);
			end
		end
		n = frame_n();
		if (!frame_loaded()) loads = n;
		else if (n > 200) loads = 0;
		else begin
			case ($urandom_range(0, 3))
				0: loads = 0;
				1: loads = $urandom_range(1, n);
				default: loads = n;
			endcase
		end
		repeat (loads) send_req(REQ_LOAD, rand_px());
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) read_px();
		if (n > 200 || $urandom_range(0, 3) != 0) run_pass();
		if (n > 200) reads = $urandom_range(20, 40);
		else if ($urandom_range(0, 2) == 0) reads = $urandom_range(1, n);
		else reads = n + $urandom_range(0, 3);
		// Once: receiver holds off while reads keep coming, so the block backs up.
		if (!hold_req && shape == 0 && reads >= 8) hold_req = 1'b1;
		repeat (reads) read_px();
		if ($urandom_range(0, 5) == 0) begin
			run_pass();
			repeat ($urandom_range(1, 8)) read_px();
		end
	endtask

	// ---- result side ---------------------------------------------------------

	// Receiver stall: bursts at a rate that changes every stretch, stretches with none,
	// and one long hold-off counted here.
	initial begin
		int mode;
		int left;
		res_stall <= 1'b0;
		mode = 0;
		left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 120);
			end
			left--;
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (!calm && mode != 0 && $urandom_range(0, (mode == 1) ? 3 : 11) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Result checker and watchdog. Values are sampled at the edge, before any flop updates.
	always @(posedge clk) begin
		res_item_t w;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_q.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$error("result beat with nothing expected: kind %0d pixel %0d last %0d",
							res_data.result_kind, res_data.pixel_out, res_data.last_pixel);
				end else begin
					w = due_q.pop_front();
					if (res_data.result_kind !== w.result_kind) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$error("result_kind: expected %0d, got %0d",
								w.result_kind, res_data.result_kind);
					end
					if (res_data.pixel_out !== w.pixel_out) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$error("pixel_out: expected %0d, got %0d",
								w.pixel_out, res_data.pixel_out);
					end
					if (res_data.last_pixel !== w.last_pixel) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$error("last_pixel: expected %0d, got %0d",
								w.last_pixel, res_data.last_pixel);
					end
				end
			end
			if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---- stimulus ------------------------------------------------------------

	initial begin
		int n;
		int a;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		small_count = 0;
		in_random = 1'b0;
		count_small = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		gap_rate = 6;
		width_reg = DIM_RESET;
		height_reg = DIM_RESET;
		load_at = 0;
		read_at = 0;

		// Directed: 5x5 frames via out-of-range register values (0 and 4 both read as 5).
		// Hole with a full ring gets its 3x3 filled; a zero on the ring blocks the fill;
		// the read after the last pixel wraps to the first.
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_IGNORE, 8'hFF}, 1, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_CFG, REG_FRAME_WIDTH, 9'd0, '0, 0, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_CFG, REG_FRAME_HEIGHT, 9'd4, '0, 0, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_FRAME, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_LOAD, 8'hFF}, NO_GAP, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_RUN, 8'h00}, 1, 1'b1, res_item_t'{KIND_PASS_DONE, 8'd0, 1'b0}});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'h00}, 1, 1'b1, res_item_t'{KIND_PIXEL, 8'hFF, 1'b0}});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'h5A}, 23, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'hFF}, 1, 1'b1, res_item_t'{KIND_PIXEL, 8'hFF, 1'b1}});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'h00}, 1, 1'b1, res_item_t'{KIND_PIXEL, 8'hFF, 1'b0}});
		dir_tab.push_back(dir_row_t'{D_FRAME, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_LOAD, 8'h01}, 0, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_RUN, 8'hFF}, 1, 1'b1, res_item_t'{KIND_PASS_DONE, 8'd0, 1'b0}});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'h00}, 1, 1'b1, res_item_t'{KIND_PIXEL, 8'd0, 1'b0}});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'hA5}, 24, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_FRAME, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_LOAD, 8'hA5}, NO_GAP, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_RUN, 8'h00}, 1, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_READ, 8'h00}, 25, 1'b0, '0});
		dir_tab.push_back(dir_row_t'{D_REQ, REG_FRAME_WIDTH, '0,
			req_item_t'{REQ_IGNORE, 8'h00}, 1, 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			case (dir_tab[i].op)
				D_CFG: write_reg(dir_tab[i].sel, dir_tab[i].val);
				D_FRAME: begin
					n = frame_n();
					repeat (n) begin
						a = load_addr();
						send(req_item_t'{REQ_LOAD,
							(a == 12 || a == dir_tab[i].cnt) ? 8'h00 : dir_tab[i].req.pixel_in},
							1'b0, '0);
					end
				end
				default: repeat (dir_tab[i].cnt) send(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
			endcase
		end

		// Random: small frames, then one 256-wide and one 256-tall frame, then small
		// frames again with idling switched off towards the end.
		in_random = 1'b1;
		while (small_count < SMALL_A) frame_episode(0);
		frame_episode(1);
		frame_episode(2);
		while (small_count < SMALL_B) frame_episode(0);

		calm = 1'b1;
		req_valid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
